// ===== hdl/vn_pkg.sv =====
// ----------------------------------------------------------------------------
// vn_pkg
// Shared constants of the vector normalizer: unit format and register reset.
// ----------------------------------------------------------------------------
package vn_pkg;

	localparam int UNIT_W    = 32;
	localparam int FRAC_BITS = 30;
	localparam int QUOT_W    = FRAC_BITS + 1;
	localparam int CFG_W     = 32;
	localparam int LANES     = 3;

	localparam logic [UNIT_W-1:0] UNIT_ONE      = 32'h4000_0000;
	localparam logic [CFG_W-1:0]  MIN_MAG_RESET = 32'd1;

endpackage

// ===== hdl/vn_front.sv =====
// ----------------------------------------------------------------------------
// vn_front
// Absolute values, split squares and sum of squares over four stages.
// ----------------------------------------------------------------------------
module vn_front import vn_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              valid_i,
	input  logic signed [DATA_WIDTH-1:0]      x_i,
	input  logic signed [DATA_WIDTH-1:0]      y_i,
	input  logic signed [DATA_WIDTH-1:0]      z_i,
	output logic                              valid_o,
	output logic [2*DATA_WIDTH-1:0]           sum_o,
	output logic [LANES-1:0][DATA_WIDTH-1:0]  abs_o,
	output logic [LANES-1:0]                  neg_o
);

	localparam int W  = DATA_WIDTH;
	localparam int LO = W / 2;
	localparam int HI = W - LO;

	logic [LANES-1:0][W-1:0]    raw;
	logic [LANES-1:0][W-1:0]    abs_s1, abs_s2, abs_s3, abs_s4;
	logic [LANES-1:0]           neg_s1, neg_s2, neg_s3, neg_s4;
	logic [LANES-1:0][2*HI-1:0] hh_s2;
	logic [LANES-1:0][W-1:0]    hl_s2;
	logic [LANES-1:0][2*LO-1:0] ll_s2;
	logic [LANES-1:0][2*W-1:0]  sq_s3;
	logic [2*W-1:0]             sum_s4;
	logic                       vld_s1, vld_s2, vld_s3, vld_s4;

	assign raw[0] = x_i;
	assign raw[1] = y_i;
	assign raw[2] = z_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= valid_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				neg_s1[l] <= raw[l][W-1];
				abs_s1[l] <= raw[l][W-1] ? (~raw[l] + 1'b1) : raw[l];
				// split each square into half-width products
				hh_s2[l]  <= abs_s1[l][W-1:LO] * abs_s1[l][W-1:LO];
				hl_s2[l]  <= abs_s1[l][W-1:LO] * abs_s1[l][LO-1:0];
				ll_s2[l]  <= abs_s1[l][LO-1:0] * abs_s1[l][LO-1:0];
				sq_s3[l]  <= ((2*W)'(hh_s2[l]) << (2*LO)) + ((2*W)'(hl_s2[l]) << (LO+1))
				           + (2*W)'(ll_s2[l]);
			end
			sum_s4 <= sq_s3[0] + sq_s3[1] + sq_s3[2];
			abs_s2 <= abs_s1;
			abs_s3 <= abs_s2;
			abs_s4 <= abs_s3;
			neg_s2 <= neg_s1;
			neg_s3 <= neg_s2;
			neg_s4 <= neg_s3;
		end
	end

	assign valid_o = vld_s4;
	assign sum_o   = sum_s4;
	assign abs_o   = abs_s4;
	assign neg_o   = neg_s4;

endmodule

// ===== hdl/vn_sqrt_stage.sv =====
// ----------------------------------------------------------------------------
// vn_sqrt_stage
// One digit-by-digit square root step: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
module vn_sqrt_stage #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [2*DATA_WIDTH-1:0] s_i,
	input  logic [DATA_WIDTH+1:0]   rem_i,
	input  logic [DATA_WIDTH-1:0]   root_i,
	output logic [2*DATA_WIDTH-1:0] s_o,
	output logic [DATA_WIDTH+1:0]   rem_o,
	output logic [DATA_WIDTH-1:0]   root_o
);

	localparam int W = DATA_WIDTH;

	logic [W+1:0]   rem_sh, trial;
	logic           take;
	logic [2*W-1:0] s_s1;
	logic [W+1:0]   rem_s1;
	logic [W-1:0]   root_s1;

	assign rem_sh = {rem_i[W-1:0], s_i[2*W-1:2*W-2]};
	assign trial  = {root_i, 2'b01};
	assign take   = rem_sh >= trial;

	always_ff @(posedge clk) begin
		if (en) begin
			s_s1    <= {s_i[2*W-3:0], 2'b00};
			rem_s1  <= take ? (rem_sh - trial) : rem_sh;
			root_s1 <= {root_i[W-2:0], take};
		end
	end

	assign s_o    = s_s1;
	assign rem_o  = rem_s1;
	assign root_o = root_s1;

endmodule

// ===== hdl/vn_div_stage.sv =====
// ----------------------------------------------------------------------------
// vn_div_stage
// One restoring division step of a component by the magnitude.
// ----------------------------------------------------------------------------
module vn_div_stage import vn_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter bit FIRST      = 1'b0
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [DATA_WIDTH-1:0] mag_i,
	input  logic [DATA_WIDTH:0]   rem_i,
	input  logic [QUOT_W-1:0]     q_i,
	output logic [DATA_WIDTH:0]   rem_o,
	output logic [QUOT_W-1:0]     q_o
);

	localparam int W = DATA_WIDTH;

	logic [W:0]        t;
	logic              take;
	logic [W:0]        rem_s1;
	logic [QUOT_W-1:0] q_s1;

	// integer step compares the component itself, later steps the doubled rest
	assign t    = FIRST ? rem_i : {rem_i[W-1:0], 1'b0};
	assign take = t >= {1'b0, mag_i};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= take ? (t - {1'b0, mag_i}) : t;
			q_s1   <= {q_i[QUOT_W-2:0], take};
		end
	end

	assign rem_o = rem_s1;
	assign q_o   = q_s1;

endmodule

// ===== hdl/vec3_normalize.sv =====
// ----------------------------------------------------------------------------
// vec3_normalize
// Magnitude and unit vector of a signed fixed-point 3D vector, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              words
//  in       input      in_valid / in_stall    in_x, in_y, in_z
//  out      output     out_valid / out_stall  unit_x/y/z, magnitude, status
//  cfg      input      cfg_valid / cfg_ready  cfg_data (min_magnitude)
//
//  One word enters per cycle while out is not stalled. Each word passes four
//  front stages, one square root stage per root bit, one compare stage, 31
//  divider stages and the output register. Reset clears all valid bits and
//  sets min_magnitude to 1. A stall on out while out_valid is high freezes
//  the whole pipeline and is passed to in_stall in the same cycle.
// ----------------------------------------------------------------------------
module vec3_normalize import vn_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [DATA_WIDTH-1:0] in_x,
	input  logic signed [DATA_WIDTH-1:0] in_y,
	input  logic signed [DATA_WIDTH-1:0] in_z,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [UNIT_W-1:0]     unit_x,
	output logic signed [UNIT_W-1:0]     unit_y,
	output logic signed [UNIT_W-1:0]     unit_z,
	output logic [DATA_WIDTH-1:0]        magnitude,
	output logic                         status,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_W-1:0]             cfg_data
);

	localparam int W  = DATA_WIDTH;
	localparam int CW = (W > CFG_W) ? W : CFG_W;
	localparam int DS = QUOT_W;

	logic                     en;
	logic [CFG_W-1:0]         min_mag_q;

	logic                     fr_vld;
	logic [2*W-1:0]           fr_sum;
	logic [LANES-1:0][W-1:0]  fr_abs;
	logic [LANES-1:0]         fr_neg;

	logic [2*W-1:0]           sq_s    [0:W];
	logic [W+1:0]             sq_rem  [0:W];
	logic [W-1:0]             sq_root [0:W];
	logic [LANES-1:0][W-1:0]  sq_abs_s [0:W-1];
	logic [LANES-1:0]         sq_neg_s [0:W-1];
	logic [W-1:0]             sq_vld_s;

	logic [W-1:0]             mag_s1;
	logic                     inv_s1;
	logic [LANES-1:0][W-1:0]  abs_s1;
	logic [LANES-1:0]         neg_s1;
	logic                     vld_s1;

	logic [W:0]               dv_rem [LANES][0:DS];
	logic [QUOT_W-1:0]        dv_q   [LANES][0:DS];
	logic [W-1:0]             dv_mag_s [0:DS-1];
	logic [LANES-1:0]         dv_neg_s [0:DS-1];
	logic [DS-1:0]            dv_inv_s;
	logic [DS-1:0]            dv_vld_s;

	logic [LANES-1:0][UNIT_W-1:0] unit_res;

	// whole pipeline advances unless the output word is held
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_mag_q <= MIN_MAG_RESET;
		end else if (cfg_valid) begin
			min_mag_q <= cfg_data;
		end
	end

	vn_front #(.DATA_WIDTH(W)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (in_valid),
		.x_i     (in_x),
		.y_i     (in_y),
		.z_i     (in_z),
		.valid_o (fr_vld),
		.sum_o   (fr_sum),
		.abs_o   (fr_abs),
		.neg_o   (fr_neg)
	);

	assign sq_s[0]    = fr_sum;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	for (genvar i = 0; i < W; i++) begin : g_sqrt
		vn_sqrt_stage #(.DATA_WIDTH(W)) u_stage (
			.clk    (clk),
			.en     (en),
			.s_i    (sq_s[i]),
			.rem_i  (sq_rem[i]),
			.root_i (sq_root[i]),
			.s_o    (sq_s[i+1]),
			.rem_o  (sq_rem[i+1]),
			.root_o (sq_root[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s <= '0;
			vld_s1   <= 1'b0;
			dv_vld_s <= '0;
		end else if (en) begin
			sq_vld_s <= {sq_vld_s[W-2:0], fr_vld};
			vld_s1   <= sq_vld_s[W-1];
			dv_vld_s <= {dv_vld_s[DS-2:0], vld_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_abs_s[0] <= fr_abs;
			sq_neg_s[0] <= fr_neg;
			for (int i = 1; i < W; i++) begin
				sq_abs_s[i] <= sq_abs_s[i-1];
				sq_neg_s[i] <= sq_neg_s[i-1];
			end
			mag_s1 <= sq_root[W];
			inv_s1 <= (sq_root[W] == '0) || (CW'(sq_root[W]) < CW'(min_mag_q));
			abs_s1 <= sq_abs_s[W-1];
			neg_s1 <= sq_neg_s[W-1];
			dv_mag_s[0] <= mag_s1;
			dv_neg_s[0] <= neg_s1;
			for (int k = 1; k < DS; k++) begin
				dv_mag_s[k] <= dv_mag_s[k-1];
				dv_neg_s[k] <= dv_neg_s[k-1];
			end
			dv_inv_s <= {dv_inv_s[DS-2:0], inv_s1};
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		assign dv_rem[l][0] = {1'b0, abs_s1[l]};
		assign dv_q[l][0]   = '0;
		for (genvar k = 0; k < DS; k++) begin : g_div
			logic [W-1:0] mag_k;
			if (k == 0) begin : g_head
				assign mag_k = mag_s1;
			end else begin : g_tail
				assign mag_k = dv_mag_s[k-1];
			end
			vn_div_stage #(.DATA_WIDTH(W), .FIRST(k == 0)) u_stage (
				.clk   (clk),
				.en    (en),
				.mag_i (mag_k),
				.rem_i (dv_rem[l][k]),
				.q_i   (dv_q[l][k]),
				.rem_o (dv_rem[l][k+1]),
				.q_o   (dv_q[l][k+1])
			);
		end
	end

	// round half up on the rest, clip to one, apply sign, zero when invalid
	always_comb begin
		logic [W+1:0]      rem2;
		logic [UNIT_W-1:0] qr;
		logic [UNIT_W-1:0] sat;
		for (int l = 0; l < LANES; l++) begin
			rem2 = {dv_rem[l][DS], 1'b0};
			qr   = UNIT_W'(dv_q[l][DS]) + UNIT_W'(rem2 >= (W+2)'(dv_mag_s[DS-1]));
			sat  = (qr > UNIT_ONE) ? UNIT_ONE : qr;
			if (dv_inv_s[DS-1]) begin
				unit_res[l] = '0;
			end else if (dv_neg_s[DS-1][l]) begin
				unit_res[l] = ~sat + 1'b1;
			end else begin
				unit_res[l] = sat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_vld_s[DS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unit_x    <= unit_res[0];
			unit_y    <= unit_res[1];
			unit_z    <= unit_res[2];
			magnitude <= dv_mag_s[DS-1];
			status    <= dv_inv_s[DS-1];
		end
	end

	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> unit_x == '0 && unit_y == '0 && unit_z == '0)
		else $error("invalid word carries nonzero unit components");

	a_zero_mag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && magnitude == '0 |-> status)
		else $error("zero magnitude reported as valid");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !status |-> $signed(unit_x) <= $signed(UNIT_ONE)
		&& $signed(unit_x) >= -$signed(UNIT_ONE))
		else $error("unit component beyond one");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(magnitude) && in_stall == out_stall)
		else $error("pipeline moved under a held output word");

endmodule

// ===== tb/tb_vec3_normalize.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vec3_normalize
// Self-checking bench for the vector normalizer. Vectors go in through the
// stall handshake with random gaps; every result word is checked field by field
// against a predicted magnitude, status and unit vector under several minimums.
// ----------------------------------------------------------------------------
module tb_vec3_normalize import vn_pkg::*;;

	localparam int DW      = 32;
	localparam int LATENCY = DW + 37;
	localparam int LIMIT   = 400000;

	typedef struct packed {
		logic signed [UNIT_W-1:0] ux;
		logic signed [UNIT_W-1:0] uy;
		logic signed [UNIT_W-1:0] uz;
		logic [DW-1:0]            mag;
		logic                     st;
	} norm_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [DW-1:0] in_x = '0, in_y = '0, in_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [UNIT_W-1:0] unit_x, unit_y, unit_z;
	logic [DW-1:0] magnitude;
	logic status;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;

	logic [CFG_W-1:0] min_mag = MIN_MAG_RESET;
	norm_t pending[$];
	int mismatches = 0;
	int n_words = 0;
	int n_invalid = 0;
	int cycles = 0;
	bit quiet = 1'b0;

	vec3_normalize #(.DATA_WIDTH(DW)) dut (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_vec3_normalize NOT OK");
			$finish;
		end
	end

	// receiver stall, off during quiet stretches
	always @(posedge clk) begin
		out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 24);
	end

	function automatic logic [DW:0] abs_of(logic signed [DW-1:0] c);
		return c[DW-1] ? (~{1'b1, c} + 1'b1) : {1'b0, c};
	endfunction

	function automatic logic [UNIT_W-1:0] unit_of(logic signed [DW-1:0] c, logic [DW:0] m);
		logic [127:0] num, q, r;
		num = {95'd0, abs_of(c)} << FRAC_BITS;
		q = num / m;
		r = num % m;
		if (2 * r >= m) q = q + 1;
		if (q > UNIT_ONE) q = UNIT_ONE;
		return c[DW-1] ? -q[UNIT_W-1:0] : q[UNIT_W-1:0];
	endfunction

	function automatic norm_t normalize(logic signed [DW-1:0] x, y, z);
		logic [127:0] sum, root, t;
		norm_t e;
		sum = abs_of(x) * abs_of(x) + abs_of(y) * abs_of(y) + abs_of(z) * abs_of(z);
		root = 0;
		for (int b = DW + 1; b >= 0; b--) begin
			t = root | (128'd1 << b);
			if (t * t <= sum) root = t;
		end
		e.mag = root[DW-1:0];
		if (e.mag == 0 || e.mag < min_mag) begin
			e.st = 1'b1;
			e.ux = '0; e.uy = '0; e.uz = '0;
		end else begin
			e.st = 1'b0;
			e.ux = unit_of(x, e.mag);
			e.uy = unit_of(y, e.mag);
			e.uz = unit_of(z, e.mag);
		end
		return e;
	endfunction

	// result checker
	always @(posedge clk) begin
		norm_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{unit_x, unit_y, unit_z, magnitude, status};
			n_words++;
			if (status) n_invalid++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word %p", got);
			end else begin
				want = pending.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p got %p", want, got);
				end
			end
		end
	end

	// drop valid only for an idle gap, so back-to-back words keep it high
	task automatic send_vec(logic signed [DW-1:0] x, y, z);
		bit idle;
		idle = !quiet && ($urandom_range(99) < 24);
		if (idle) in_valid <= 1'b0;
		while (idle) begin
			@(posedge clk);
			idle = !quiet && ($urandom_range(99) < 24);
		end
		in_valid <= 1'b1;
		in_x <= x; in_y <= y; in_z <= z;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending.push_back(normalize(x, y, z));
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic set_min(logic [CFG_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		min_mag = v;
	endtask

	function automatic logic signed [DW-1:0] rnd_comp();
		case ($urandom_range(5))
			0: return $urandom_range(1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
			1: return $signed($urandom_range(65535)) - 32768;
			2: return $signed($urandom_range(2000)) - 1000;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_edges;
		send_vec(0, 0, 0);
		send_vec(1, 0, 0);
		send_vec(-1, 0, 0);
		send_vec(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		send_vec(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
		send_vec(32'sh8000_0000, 0, 0);
		send_vec(0, 32'sh7fff_ffff, 0);
		send_vec(0, 0, -65536);
		send_vec(65536, 65536, 65536);
		send_vec(3, 4, 0);
		send_vec(-3, 4, -12);
		send_vec(1, 1, 1);
		send_vec(-1, -1, -1);
		send_vec(32'sh8000_0000, 1, -1);
	endtask

	task automatic test_minimum;
		set_min(0);
		send_vec(0, 0, 0);
		send_vec(0, 1, 0);
		set_min(32'hffff_ffff);
		send_vec(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		send_vec(12345, -678, 9);
		set_min(100);
		send_vec(99, 0, 0);
		send_vec(100, 0, 0);
		send_vec(60, 80, 0);
		send_vec(59, 80, 0);
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			if (i == n / 3) quiet = 1'b1;
			if (i == n / 2) quiet = 1'b0;
			send_vec(rnd_comp(), rnd_comp(), rnd_comp());
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edges();
		test_minimum();
		set_min(1);
		test_random(450);
		set_min($urandom_range(40000));
		test_random(450);
		set_min($urandom);
		test_random(200);
		set_min(0);
		test_random(230);
		drain();
		$display("checked %0d result words, %0d below minimum, across several minimum settings",
			n_words, n_invalid);
		if (mismatches == 0 && pending.size() == 0) begin
			$display("tb_vec3_normalize OK");
		end else begin
			$display("%0d mismatches, %0d words missing", mismatches, pending.size());
			$display("tb_vec3_normalize NOT OK");
		end
		$finish;
	end

endmodule

// ===== vec3_normalize.f =====
hdl/vn_pkg.sv
hdl/vn_front.sv
hdl/vn_sqrt_stage.sv
hdl/vn_div_stage.sv
hdl/vec3_normalize.sv
tb/tb_vec3_normalize.sv
